FILE: hw/rtl/dft64_pkg.sv
// Shared widths, defaults and the control type for the 64-point real-input DFT core.
package dft64_pkg;

  localparam int SAMPLE_W         = 16;
  localparam int BIN_W            = 6;
  localparam int PART_W           = 23;
  localparam int IN_TDATA_W       = 16;
  localparam int OUT_TDATA_W      = 56;
  localparam int POINTS_DEF       = 64;
  localparam int TWIDDLE_BITS_DEF = 16;

  // pi/2 in Q30
  localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;
  localparam longint unsigned ONE_Q30     = 64'd1 << 30;

  // control that travels with one product into the MAC unit
  typedef struct packed {
    logic valid;
    logic first;
  } mac_ctrl_t;

endpackage

FILE: hw/rtl/dft64_mac.sv
// Shared complex multiply-accumulate unit: two registered products and two accumulators.
module dft64_mac import dft64_pkg::*; #(
  parameter int TWIDDLE_BITS = TWIDDLE_BITS_DEF,
  parameter int ACC_W        = SAMPLE_W + TWIDDLE_BITS + 7
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  mac_ctrl_t                      ctrl_i,
  input  logic signed [SAMPLE_W-1:0]     sample_i,
  input  logic signed [TWIDDLE_BITS:0]   cos_i,
  input  logic signed [TWIDDLE_BITS:0]   sin_i,
  output logic signed [ACC_W-1:0]        acc_re_o,
  output logic signed [ACC_W-1:0]        acc_im_o,
  output logic                           busy_o
);

  localparam int PROD_W = SAMPLE_W + TWIDDLE_BITS + 1;

  logic signed [PROD_W-1:0] prod_re_d, prod_re_q;
  logic signed [PROD_W-1:0] prod_im_d, prod_im_q;
  logic                     prod_vld_q, prod_first_q;
  logic signed [ACC_W-1:0]  acc_re_d, acc_re_q;
  logic signed [ACC_W-1:0]  acc_im_d, acc_im_q;

  assign prod_re_d = PROD_W'(sample_i * cos_i);
  assign prod_im_d = PROD_W'(sample_i * sin_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q   <= 1'b0;
      prod_first_q <= 1'b0;
    end else begin
      prod_vld_q   <= ctrl_i.valid;
      prod_first_q <= ctrl_i.first;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_re_q <= prod_re_d;
    prod_im_q <= prod_im_d;
  end

  // imaginary sum is minus x*sin
  always_comb begin
    acc_re_d = acc_re_q;
    acc_im_d = acc_im_q;
    if (prod_vld_q) begin
      if (prod_first_q) begin
        acc_re_d = ACC_W'(prod_re_q);
        acc_im_d = -ACC_W'(prod_im_q);
      end else begin
        acc_re_d = acc_re_q + ACC_W'(prod_re_q);
        acc_im_d = acc_im_q - ACC_W'(prod_im_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_re_q <= acc_re_d;
    acc_im_q <= acc_im_d;
  end

  assign acc_re_o = acc_re_q;
  assign acc_im_o = acc_im_q;
  assign busy_o   = prod_vld_q;

endmodule

FILE: hw/rtl/dft_64_point_real_input_core.sv
// Top level: sample store, twiddle ROM, bin sequencer and output register of the DFT core.
// Input: one sample per beat; 64 beats fill a frame, then the input stalls while bins compute.
// Each bin runs on the shared MAC unit: one issue per sample, then the read, product and
// accumulator registers drain before the output load.
// Output stalls hold a finished bin in the drain state until the output register is free.
// Reset clears the fill count, sequencer and output valid; the sample store is not cleared.
module dft_64_point_real_input_core import dft64_pkg::*; #(
  parameter int POINTS       = POINTS_DEF,
  parameter int TWIDDLE_BITS = TWIDDLE_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [15:0] sample
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [5:0] bin_index, [28:6] real_part,
                                                 // [51:29] imag_part, [55:52] zero
  output logic                   m_axis_tlast    // last_bin
);

  localparam int TB    = TWIDDLE_BITS;
  localparam int KW    = $clog2(POINTS);
  localparam int ACC_W = SAMPLE_W + TB + 1 + KW;

  localparam logic [1:0] ST_FILL  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  localparam logic [KW-1:0]        LAST_IDX = KW'(POINTS - 1);
  localparam logic [KW:0]          PTS_EXT  = (KW + 1)'(POINTS);
  localparam logic signed [ACC_W-1:0] RND_BIAS = ACC_W'(64'd1 << (TB - 2));

  // ---------------- twiddle table, built at elaboration ----------------
  function automatic longint unsigned qmul(input longint unsigned a, input longint unsigned b);
    return (a * b + (64'd1 << 29)) >> 30;
  endfunction

  function automatic longint tay_cos(input longint unsigned xx);
    longint unsigned t;
    longint          sum;
    t = ONE_Q30;
    sum = longint'(t);
    t = qmul(t, xx) / 64'd2;   sum -= longint'(t);
    t = qmul(t, xx) / 64'd12;  sum += longint'(t);
    t = qmul(t, xx) / 64'd30;  sum -= longint'(t);
    t = qmul(t, xx) / 64'd56;  sum += longint'(t);
    t = qmul(t, xx) / 64'd90;  sum -= longint'(t);
    t = qmul(t, xx) / 64'd132; sum += longint'(t);
    t = qmul(t, xx) / 64'd182; sum -= longint'(t);
    t = qmul(t, xx) / 64'd240; sum += longint'(t);
    t = qmul(t, xx) / 64'd306; sum -= longint'(t);
    t = qmul(t, xx) / 64'd380; sum += longint'(t);
    t = qmul(t, xx) / 64'd462; sum -= longint'(t);
    t = qmul(t, xx) / 64'd552; sum += longint'(t);
    t = qmul(t, xx) / 64'd650; sum -= longint'(t);
    t = qmul(t, xx) / 64'd756; sum += longint'(t);
    return sum;
  endfunction

  function automatic longint tay_sin(input longint unsigned x, input longint unsigned xx);
    longint unsigned t;
    longint          sum;
    t = x;
    sum = longint'(t);
    t = qmul(t, xx) / 64'd6;   sum -= longint'(t);
    t = qmul(t, xx) / 64'd20;  sum += longint'(t);
    t = qmul(t, xx) / 64'd42;  sum -= longint'(t);
    t = qmul(t, xx) / 64'd72;  sum += longint'(t);
    t = qmul(t, xx) / 64'd110; sum -= longint'(t);
    t = qmul(t, xx) / 64'd156; sum += longint'(t);
    t = qmul(t, xx) / 64'd210; sum -= longint'(t);
    t = qmul(t, xx) / 64'd272; sum += longint'(t);
    t = qmul(t, xx) / 64'd342; sum -= longint'(t);
    t = qmul(t, xx) / 64'd420; sum += longint'(t);
    t = qmul(t, xx) / 64'd506; sum -= longint'(t);
    t = qmul(t, xx) / 64'd600; sum += longint'(t);
    t = qmul(t, xx) / 64'd702; sum -= longint'(t);
    t = qmul(t, xx) / 64'd812; sum += longint'(t);
    return sum;
  endfunction

  function automatic logic signed [TB:0] q30_tw(input longint v);
    longint          c;
    longint unsigned u;
    c = v;
    if (c < 0) c = 0;
    if (c > longint'(ONE_Q30)) c = longint'(ONE_Q30);
    u = longint'(c);
    return (TB + 1)'((u + (64'd1 << (30 - TB))) >> (31 - TB));
  endfunction

  function automatic logic signed [TB:0] tw_entry(input int unsigned mi, input bit sel_sin);
    longint unsigned u, q, r, x, xx;
    logic signed [TB:0] c, s, cv, sv;
    u  = 64'd4 * longint'(mi);
    q  = u / POINTS;
    r  = u - q * POINTS;
    x  = (PI_HALF_Q30 * r + POINTS / 2) / POINTS;
    xx = (x * x + (64'd1 << 29)) >> 30;
    c  = q30_tw(tay_cos(xx));
    s  = q30_tw(tay_sin(x, xx));
    case (q[1:0])
      2'd0: begin cv = c;  sv = s;  end
      2'd1: begin cv = -s; sv = c;  end
      2'd2: begin cv = -c; sv = -s; end
      default: begin cv = s; sv = -c; end
    endcase
    return sel_sin ? sv : cv;
  endfunction

  logic signed [TB:0] rom_cos [POINTS];
  logic signed [TB:0] rom_sin [POINTS];

  for (genvar g = 0; g < POINTS; g++) begin : g_rom
    localparam logic signed [TB:0] COS_V = tw_entry(g, 1'b0);
    localparam logic signed [TB:0] SIN_V = tw_entry(g, 1'b1);
    assign rom_cos[g] = COS_V;
    assign rom_sin[g] = SIN_V;
  end

  // ---------------- sequencer ----------------
  logic [1:0]    st_d, st_q;
  logic [KW-1:0] fill_d, fill_q;
  logic [KW-1:0] n_d, n_q;
  logic [KW-1:0] m_d, m_q;
  logic [KW-1:0] k_d, k_q;
  logic [KW:0]   m_sum;
  logic          in_beat, issue, load;

  logic signed [SAMPLE_W-1:0] smp_mem [POINTS];
  logic signed [SAMPLE_W-1:0] rd_smp_q;
  logic signed [TB:0]         tw_cos_q, tw_sin_q;
  logic                       s1_vld_q, s1_first_q;

  mac_ctrl_t                  mac_ctrl;
  logic signed [ACC_W-1:0]    acc_re, acc_im;
  logic                       mac_busy;

  logic                       out_vld_d, out_vld_q;
  logic [BIN_W-1:0]           out_bin_q;
  logic signed [PART_W-1:0]   out_re_q, out_im_q;
  logic                       out_last_q;
  logic signed [ACC_W-1:0]    rnd_re, rnd_im;
  logic signed [ACC_W-1:0]    sh_re, sh_im;

  assign s_axis_tready = (st_q == ST_FILL);
  assign in_beat       = s_axis_tvalid && s_axis_tready;

  // next twiddle index k*(n+1) mod POINTS, one compare and subtract
  assign m_sum = {1'b0, m_q} + {1'b0, k_q};

  always_comb begin
    st_d   = st_q;
    fill_d = fill_q;
    n_d    = n_q;
    m_d    = m_q;
    k_d    = k_q;
    issue  = 1'b0;
    load   = 1'b0;
    case (st_q)
      ST_FILL: begin
        if (in_beat) begin
          if (fill_q == LAST_IDX) begin
            fill_d = '0;
            st_d   = ST_RUN;
            n_d    = '0;
            m_d    = '0;
            k_d    = '0;
          end else begin
            fill_d = fill_q + 1'b1;
          end
        end
      end
      ST_RUN: begin
        issue = 1'b1;
        n_d   = n_q + 1'b1;
        m_d   = (m_sum >= PTS_EXT) ? KW'(m_sum - PTS_EXT) : KW'(m_sum);
        if (n_q == LAST_IDX) begin
          st_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!s1_vld_q && !mac_busy && (!out_vld_q || m_axis_tready)) begin
          load = 1'b1;
          n_d  = '0;
          m_d  = '0;
          if (k_q == LAST_IDX) begin
            st_d = ST_FILL;
          end else begin
            k_d  = k_q + 1'b1;
            st_d = ST_RUN;
          end
        end
      end
      default: st_d = ST_FILL;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= ST_FILL;
      fill_q     <= '0;
      n_q        <= '0;
      m_q        <= '0;
      k_q        <= '0;
      s1_vld_q   <= 1'b0;
      s1_first_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      st_q       <= st_d;
      fill_q     <= fill_d;
      n_q        <= n_d;
      m_q        <= m_d;
      k_q        <= k_d;
      s1_vld_q   <= issue;
      s1_first_q <= (n_q == '0);
      out_vld_q  <= out_vld_d;
    end
  end

  // sample store and registered reads
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      smp_mem[fill_q] <= s_axis_tdata[SAMPLE_W-1:0];
    end
    rd_smp_q <= smp_mem[n_q];
    tw_cos_q <= rom_cos[m_q];
    tw_sin_q <= rom_sin[m_q];
  end

  assign mac_ctrl.valid = s1_vld_q;
  assign mac_ctrl.first = s1_first_q;

  dft64_mac #(
    .TWIDDLE_BITS (TB),
    .ACC_W        (ACC_W)
  ) u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (mac_ctrl),
    .sample_i (rd_smp_q),
    .cos_i    (tw_cos_q),
    .sin_i    (tw_sin_q),
    .acc_re_o (acc_re),
    .acc_im_o (acc_im),
    .busy_o   (mac_busy)
  );

  // round half up to sample units
  assign rnd_re = acc_re + RND_BIAS;
  assign rnd_im = acc_im + RND_BIAS;
  assign sh_re  = rnd_re >>> (TB - 1);
  assign sh_im  = rnd_im >>> (TB - 1);

  always_comb begin
    out_vld_d = out_vld_q;
    if (load) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_bin_q  <= BIN_W'(k_q);
      out_re_q   <= PART_W'(sh_re);
      out_im_q   <= PART_W'(sh_im);
      out_last_q <= (k_q == LAST_IDX);
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {(OUT_TDATA_W - BIN_W - 2 * PART_W)'(0), out_im_q, out_re_q, out_bin_q};
  assign m_axis_tlast  = out_last_q;

endmodule

FILE: hw/rtl/dft64_checker.sv
// Port-level checker for the DFT core, bound to the top level.
module dft64_checker import dft64_pkg::*; #(
  parameter int POINTS = POINTS_DEF
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                   m_axis_tlast
);

  localparam int KW = $clog2(POINTS);
  localparam logic [KW-1:0] LAST_IDX = KW'(POINTS - 1);

  logic [KW-1:0] in_cnt_q, exp_bin_q;
  logic          in_beat, out_beat;

  assign in_beat  = s_axis_tvalid && s_axis_tready;
  assign out_beat = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_cnt_q  <= '0;
      exp_bin_q <= '0;
    end else begin
      if (in_beat) begin
        in_cnt_q <= (in_cnt_q == LAST_IDX) ? '0 : in_cnt_q + 1'b1;
      end
      if (out_beat) begin
        exp_bin_q <= (exp_bin_q == LAST_IDX) ? '0 : exp_bin_q + 1'b1;
      end
    end
  end

  // bins come out in order, wrapping each frame
  a_bin_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[BIN_W-1:0] == BIN_W'(exp_bin_q))
    else $error("bin index out of order");

  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == (exp_bin_q == LAST_IDX)))
    else $error("tlast not on final bin");

  // input stalls once a frame is complete
  a_frame_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat && (in_cnt_q == LAST_IDX) |=> !s_axis_tready)
    else $error("input accepted during compute");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output beat changed");

endmodule

bind dft_64_point_real_input_core dft64_checker #(.POINTS(POINTS)) u_dft64_checker (.*);

FILE: tb/sv/tb_dft_64_point_real_input_core.sv
`timescale 1ns / 100ps
// Testbench for the 64-point real-input DFT core: streams sample frames and checks every bin.
module tb_dft_64_point_real_input_core;
  import dft64_pkg::*;

  localparam int NPTS = POINTS_DEF;
  localparam int TWB  = TWIDDLE_BITS_DEF;
  localparam int FRAC = TWB - 1;

  typedef struct {
    logic [BIN_W-1:0]  bin;
    logic [PART_W-1:0] re;
    logic [PART_W-1:0] im;
    logic              last;
  } dft_bin_t;

  typedef enum logic [1:0] {QUAD_0, QUAD_1, QUAD_2, QUAD_3} quadrant_e;
  typedef enum int {FILL_FULL, FILL_QUIET, FILL_EDGES, FILL_SPARSE} fill_style_e;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // [15:0] sample
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;   // [5:0] bin_index, [28:6] real_part, [51:29] imag_part
  logic                   m_axis_tlast;   // last_bin

  int tw_cos [NPTS];
  int tw_sin [NPTS];
  logic signed [SAMPLE_W-1:0] frame_buf [NPTS];
  int          frame_fill = 0;
  fill_style_e cur_style = FILL_FULL;
  dft_bin_t    pending_bins [$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int rx_hold_left  = 0;
  int errors        = 0;
  int bins_checked  = 0;
  int frames_done   = 0;
  int beats_sent    = 0;

  dft_64_point_real_input_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // alternating Taylor series in Q30, cosine or sine flavor
  function automatic longint taylor_q30(longint unsigned start, longint unsigned xx, bit sine);
    longint unsigned term;
    longint unsigned div;
    longint          total;
    term  = start;
    total = longint'(start);
    for (int i = 1; i <= 14; i++) begin
      div  = sine ? longint'((2 * i) * (2 * i + 1)) : longint'((2 * i - 1) * (2 * i));
      term = ((term * xx + (64'd1 << 29)) >> 30) / div;
      if (i % 2) total -= longint'(term);
      else total += longint'(term);
    end
    return total;
  endfunction

  function automatic int q30_to_twiddle(longint v);
    if (v < 0) v = 0;
    if (v > longint'(ONE_Q30)) v = longint'(ONE_Q30);
    return int'((v + (longint'(1) << (30 - TWB))) >>> (31 - TWB));
  endfunction

  task automatic build_twiddles();
    longint unsigned u, quad, rem, x, xx;
    int c, s;
    for (int m = 0; m < NPTS; m++) begin
      u    = 4 * m;
      quad = u / NPTS;
      rem  = u - quad * NPTS;
      x    = (PI_HALF_Q30 * rem + NPTS / 2) / NPTS;
      xx   = (x * x + (64'd1 << 29)) >> 30;
      c    = q30_to_twiddle(taylor_q30(ONE_Q30, xx, 1'b0));
      s    = q30_to_twiddle(taylor_q30(x, xx, 1'b1));
      case (quadrant_e'(quad[1:0]))
        QUAD_0: begin tw_cos[m] = c;  tw_sin[m] = s;  end
        QUAD_1: begin tw_cos[m] = -s; tw_sin[m] = c;  end
        QUAD_2: begin tw_cos[m] = -c; tw_sin[m] = -s; end
        default: begin tw_cos[m] = s; tw_sin[m] = -c; end
      endcase
    end
  endtask

  // direct DFT of the stored frame; one expected bin per k
  task automatic predict_spectrum();
    longint   acc_re, acc_im;
    int       m;
    dft_bin_t b;
    for (int k = 0; k < NPTS; k++) begin
      acc_re = 0;
      acc_im = 0;
      for (int n = 0; n < NPTS; n++) begin
        m = (k * n) % NPTS;
        acc_re += longint'(frame_buf[n]) * tw_cos[m];
        acc_im -= longint'(frame_buf[n]) * tw_sin[m];
      end
      b.bin  = BIN_W'(k);
      b.re   = PART_W'((acc_re + (longint'(1) << (FRAC - 1))) >>> FRAC);
      b.im   = PART_W'((acc_im + (longint'(1) << (FRAC - 1))) >>> FRAC);
      b.last = (k == NPTS - 1);
      pending_bins.push_back(b);
    end
  endtask

  // valid stays high after a beat; the next call either idles or presents new data
  task automatic send_sample(input logic [SAMPLE_W-1:0] smp);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= smp;
    do @(posedge clk_i); while (!s_axis_tready);
    beats_sent++;
    frame_buf[frame_fill] = smp;
    frame_fill++;
    if (frame_fill == NPTS) begin
      predict_spectrum();
      frame_fill = 0;
    end
  endtask

  function automatic logic [SAMPLE_W-1:0] random_sample(fill_style_e style);
    case (style)
      FILL_FULL:  return SAMPLE_W'($urandom);
      FILL_QUIET: return SAMPLE_W'($urandom_range(0, 511) - 256);
      FILL_EDGES: begin
        case ($urandom_range(0, 4))
          0: return 16'h8000;
          1: return 16'h7fff;
          2: return 16'h0000;
          3: return 16'hffff;
          default: return SAMPLE_W'($urandom);
        endcase
      end
      default: return ($urandom_range(0, 7) == 0) ? SAMPLE_W'($urandom) : '0;
    endcase
  endfunction

  task automatic send_random(int count);
    repeat (count) begin
      if (frame_fill == 0) cur_style = fill_style_e'($urandom_range(0, 3));
      send_sample(random_sample(cur_style));
    end
  endtask

  // all samples at the negative rail: DC bin reaches -2^21, the most negative sum the samples can give
  task automatic test_dc_extreme();
    repeat (NPTS) send_sample(16'h8000);
  endtask

  // full-scale alternation puts nearly all energy in the Nyquist bin
  task automatic test_alternating_full_scale();
    for (int n = 0; n < NPTS; n++) send_sample((n % 2) ? 16'h8000 : 16'h7fff);
  endtask

  // completes any open frame, then whole random frames
  task automatic test_random_frames(int nframes);
    send_random(nframes * NPTS + ((frame_fill != 0) ? NPTS - frame_fill : 0));
  endtask

  // output held off right after a frame completes; new samples wait behind the stalled bins
  task automatic test_output_hold_off();
    rx_hold_left = 2500;
    send_random(NPTS / 2 - 4);
  endtask

  // samples that never complete a frame must produce nothing
  task automatic test_partial_tail();
    send_random(10);
  endtask

  always @(posedge clk_i) begin
    if (rx_hold_left > 0) begin
      m_axis_tready <= 1'b0;
      rx_hold_left--;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin : bin_checker
    dft_bin_t          want;
    logic [BIN_W-1:0]  got_bin;
    logic [PART_W-1:0] got_re, got_im;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_bin = m_axis_tdata[BIN_W-1:0];
      got_re  = m_axis_tdata[BIN_W +: PART_W];
      got_im  = m_axis_tdata[BIN_W + PART_W +: PART_W];
      if (pending_bins.size() == 0) begin
        $error("unexpected output beat: bin_index %0d", got_bin);
        errors++;
      end else begin
        want = pending_bins.pop_front();
        bins_checked++;
        if (got_bin !== want.bin) begin
          $error("bin_index: expected %0d, got %0d", want.bin, got_bin);
          errors++;
        end
        if (got_re !== want.re) begin
          $error("real_part (bin %0d): expected %0d, got %0d",
                 want.bin, $signed(want.re), $signed(got_re));
          errors++;
        end
        if (got_im !== want.im) begin
          $error("imag_part (bin %0d): expected %0d, got %0d",
                 want.bin, $signed(want.im), $signed(got_im));
          errors++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("last_bin (bin %0d): expected %0b, got %0b", want.bin, want.last, m_axis_tlast);
          errors++;
        end
        if (want.last) frames_done++;
      end
    end
  end

  initial begin
    build_twiddles();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 27;
    recv_idle_pct = 82;
    test_dc_extreme();
    test_alternating_full_scale();

    send_idle_pct = 82;
    recv_idle_pct = 27;
    test_random_frames(1);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_output_hold_off();
    test_partial_tail();
    s_axis_tvalid <= 1'b0;

    while (pending_bins.size() != 0) @(posedge clk_i);
    repeat (2 * (NPTS + 4)) @(posedge clk_i);

    $display("Run covered %0d sample beats and %0d complete frames (%0d bins compared),",
             beats_sent, frames_done, bins_checked);
    $display("with rail and alternating frames, random content, output hold-off, partial tail.");
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d bins still expected", pending_bins.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/dft64_pkg.sv
hw/rtl/dft64_mac.sv
hw/rtl/dft_64_point_real_input_core.sv
hw/rtl/dft64_checker.sv
tb/sv/tb_dft_64_point_real_input_core.sv
